FILE: hdl/ldm_pkg.sv
// Shared types, constants and the saturating add helper for the lens distortion mapper.
`default_nettype none
package ldm_pkg;

  localparam int WORD_W  = 64;
  localparam int MAG_W   = WORD_W - 1;
  localparam int LO_W    = 32;
  localparam int HI_W    = MAG_W - LO_W;
  localparam int PROD_W  = 2 * MAG_W + 1;
  localparam int FRAC_N  = 28;
  localparam int NORM_SH = 18;
  localparam int MUL_LAT = 4;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_CENTER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_INV_FOCAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_FOCAL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_CENTER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K1_K2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K3     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TANG_P1_P2    = 3'd6;

  localparam logic [CFG_W-1:0] SRC_INV_FOCAL_RST = 64'h4000_0000_4000_0000;
  localparam logic [CFG_W-1:0] DST_FOCAL_RST     = 64'h0001_0000_0001_0000;

  localparam logic signed [WORD_W-1:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [WORD_W-1:0] SAT_MIN = 64'sh8000_0000_0000_0001;
  localparam logic signed [WORD_W-1:0] ONE_Q28 = 64'sh0000_0000_1000_0000;

  // Rounding shift applied after a product.
  typedef enum logic [1:0] {
    SH_Q28,
    SH_Q27,
    SH_Q18
  } sh_sel_t;

  typedef struct packed {
    logic signed [23:0] x_in;
    logic signed [23:0] y_in;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] x_out;
    logic signed [23:0] y_out;
    logic               clipped;
  } out_item_t;

  typedef struct packed {
    logic                     sat;
    logic signed [WORD_W-1:0] val;
  } sat_val_t;

  // Signed add that clamps to +-(2^63 - 1) and reports the clamp.
  function automatic sat_val_t add_sat(input logic signed [WORD_W-1:0] a,
                                       input logic signed [WORD_W-1:0] b);
    logic signed [WORD_W:0] s;
    sat_val_t               r;
    s = $signed({a[WORD_W-1], a}) + $signed({b[WORD_W-1], b});
    if (s > $signed({SAT_MAX[WORD_W-1], SAT_MAX})) begin
      r.sat = 1'b1;
      r.val = SAT_MAX;
    end else if (s < $signed({SAT_MIN[WORD_W-1], SAT_MIN})) begin
      r.sat = 1'b1;
      r.val = SAT_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = s[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/ldm_dly.sv
// Fixed-length delay line that keeps operands aligned with the pipeline.
`default_nettype none
module ldm_dly #(
  parameter int W = 64,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    tap_r[0] <= d;
    for (int i = 1; i < N; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[N-1];

endmodule
`default_nettype wire

FILE: hdl/ldm_mul.sv
// Four-stage signed multiplier with rounding right shift and saturation.
`default_nettype none
module ldm_mul (
  input  wire logic                            clk,
  input  wire logic signed [ldm_pkg::WORD_W-1:0] a,
  input  wire logic signed [ldm_pkg::WORD_W-1:0] b,
  input  wire ldm_pkg::sh_sel_t                sh_sel,
  output logic signed      [ldm_pkg::WORD_W-1:0] p,
  output logic                                 sat
);

  localparam int WORD_W = ldm_pkg::WORD_W;
  localparam int MAG_W  = ldm_pkg::MAG_W;
  localparam int LO_W   = ldm_pkg::LO_W;
  localparam int PROD_W = ldm_pkg::PROD_W;
  localparam int FRAC_N = ldm_pkg::FRAC_N;
  localparam int NSH    = ldm_pkg::NORM_SH;

  // Stage 1: sign and magnitudes.
  logic              neg1_r;
  logic [MAG_W-1:0]  ua_r, ub_r;
  logic [WORD_W-1:0] a_neg, b_neg;
  logic [MAG_W-1:0]  ua_nxt, ub_nxt;

  always_comb begin
    a_neg  = WORD_W'(-a);
    b_neg  = WORD_W'(-b);
    ua_nxt = a[WORD_W-1] ? a_neg[MAG_W-1:0] : a[MAG_W-1:0];
    ub_nxt = b[WORD_W-1] ? b_neg[MAG_W-1:0] : b[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    neg1_r <= a[WORD_W-1] ^ b[WORD_W-1];
    ua_r   <= ua_nxt;
    ub_r   <= ub_nxt;
  end

  // Stage 2: four partial products of the 32-bit low and 31-bit high halves.
  logic              neg2_r;
  logic [2*LO_W-1:0] pp00_r, pp01_r, pp10_r, pp11_r;

  always_ff @(posedge clk) begin
    neg2_r <= neg1_r;
    pp00_r <= (2*LO_W)'(ua_r[LO_W-1:0]) * (2*LO_W)'(ub_r[LO_W-1:0]);
    pp01_r <= (2*LO_W)'(ua_r[LO_W-1:0]) * (2*LO_W)'(ub_r[MAG_W-1:LO_W]);
    pp10_r <= (2*LO_W)'(ua_r[MAG_W-1:LO_W]) * (2*LO_W)'(ub_r[LO_W-1:0]);
    pp11_r <= (2*LO_W)'(ua_r[MAG_W-1:LO_W]) * (2*LO_W)'(ub_r[MAG_W-1:LO_W]);
  end

  // Stage 3: full product plus the half-LSB rounding constant.
  logic              neg3_r;
  logic [PROD_W-1:0] sum_r, sum_nxt, rnd;

  always_comb begin
    unique case (sh_sel)
      ldm_pkg::SH_Q28: rnd = PROD_W'(1) << (FRAC_N - 1);
      ldm_pkg::SH_Q27: rnd = PROD_W'(1) << (FRAC_N - 2);
      ldm_pkg::SH_Q18: rnd = PROD_W'(1) << (NSH - 1);
      default:         rnd = '0;
    endcase
    sum_nxt = PROD_W'(pp00_r) + (PROD_W'(pp01_r) << LO_W) + (PROD_W'(pp10_r) << LO_W)
            + (PROD_W'(pp11_r) << (2 * LO_W)) + rnd;
  end

  always_ff @(posedge clk) begin
    neg3_r <= neg2_r;
    sum_r  <= sum_nxt;
  end

  // Stage 4: shift, clamp the magnitude and restore the sign.
  logic [PROD_W-1:0]        shv;
  logic                     sat_nxt;
  logic [MAG_W-1:0]         mag;
  logic signed [WORD_W-1:0] p_nxt;
  logic signed [WORD_W-1:0] p_r;
  logic                     sat_r;

  always_comb begin
    unique case (sh_sel)
      ldm_pkg::SH_Q28: shv = sum_r >> FRAC_N;
      ldm_pkg::SH_Q27: shv = sum_r >> (FRAC_N - 1);
      ldm_pkg::SH_Q18: shv = sum_r >> NSH;
      default:         shv = sum_r;
    endcase
    sat_nxt = |shv[PROD_W-1:MAG_W];
    mag     = sat_nxt ? {MAG_W{1'b1}} : shv[MAG_W-1:0];
    p_nxt   = neg3_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    sat_r <= sat_nxt;
  end

  assign p   = p_r;
  assign sat = sat_r;

endmodule
`default_nettype wire

FILE: hdl/lens_distortion_mapper.sv
// Top level of the Brown-Conrady lens distortion mapper pipeline.
`default_nettype none
// Maps one undistorted pixel point (signed Q16.8) to its distorted position.
// Input: an item is taken at a rising edge where start is high and busy is low.
// busy is high while reset is held and for the first cycle after reset, so one item
// can be taken every clock cycle. Each item yields exactly one result.
// Output: the result is on out_data for one cycle with out_valid high; the receiver
// has no way to hold results off and none are buffered. The sustained rate is one
// item per cycle. The pipeline is a chain of seven dependent multiplies (normalize,
// square, r^4, r^6, k3 term, radial scale, projection), each a four-stage 64-bit
// unit built from partial products of the 32-bit and 31-bit operand halves, plus
// the saturating add stages between them.
// Configuration: seven registers written over cfg_valid/cfg_ready with a register
// index; cfg_ready is always high and unknown indexes are dropped. Registers are
// read live by the datapath, so writes belong in idle periods.
// Reset (synchronous, active low) restores register defaults and clears all
// valid bits in the pipeline; data in flight is discarded.
// clipped is set when any intermediate value or output coordinate saturated.
module lens_distortion_mapper (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire ldm_pkg::in_item_t                   in_data,
  output logic                                     out_valid,
  output ldm_pkg::out_item_t                       out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ldm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ldm_pkg::CFG_W-1:0]           cfg_data
);

  localparam int W  = ldm_pkg::WORD_W;
  localparam int ML = ldm_pkg::MUL_LAT;

  // Pipeline stage at which each value sits in a register.
  localparam int ST_D    = 1;
  localparam int ST_XN   = ST_D + ML;
  localparam int ST_SQ   = ST_XN + ML;
  localparam int ST_R2   = ST_SQ + 1;
  localparam int ST_T    = ST_R2 + 1;
  localparam int ST_PXY  = ST_SQ + ML;
  localparam int ST_R4   = ST_R2 + ML;
  localparam int ST_PT   = ST_T + ML;
  localparam int ST_RAD1 = ST_R4 + 1;
  localparam int ST_R6   = ST_R4 + ML;
  localparam int ST_RAD2 = ST_R6 + 1;
  localparam int ST_K3   = ST_R6 + ML;
  localparam int ST_RAD3 = ST_K3 + 1;
  localparam int ST_D0   = ST_RAD3 + ML;
  localparam int ST_D1   = ST_D0 + 1;
  localparam int ST_D2   = ST_D1 + 1;
  localparam int ST_P0   = ST_D2 + ML;
  localparam int ST_P1   = ST_P0 + 1;
  localparam int ST_ABS  = ST_P1 + 1;
  localparam int ST_OUT  = ST_ABS + 1;

  typedef struct packed {
    logic        sat;
    logic [23:0] val;
  } clamp_t;

  // Rounds a Q.16 magnitude to Q.8 and clamps the signed result to 24 bits.
  function automatic clamp_t to_out24(input logic neg, input logic [W-2:0] mag);
    logic [W-1:0]   rs;
    logic [W-9:0]   m;
    clamp_t         r;
    rs = W'(mag) + W'(128);
    m  = rs[W-1:8];
    if (neg) begin
      r.sat = (m > (W-8)'(8388608));
      r.val = r.sat ? 24'h800000 : (24'd0 - m[23:0]);
    end else begin
      r.sat = (m > (W-8)'(8388607));
      r.val = r.sat ? 24'h7FFFFF : m[23:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [63:0] src_center_r, src_inv_focal_r, dst_focal_r, dst_center_r;
  logic [63:0] radial_k1_k2_r, tang_p1_p2_r;
  logic [31:0] radial_k3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_center_r    <= '0;
      src_inv_focal_r <= ldm_pkg::SRC_INV_FOCAL_RST;
      dst_focal_r     <= ldm_pkg::DST_FOCAL_RST;
      dst_center_r    <= '0;
      radial_k1_k2_r  <= '0;
      radial_k3_r     <= '0;
      tang_p1_p2_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ldm_pkg::REG_SRC_CENTER:    src_center_r    <= cfg_data;
        ldm_pkg::REG_SRC_INV_FOCAL: src_inv_focal_r <= cfg_data;
        ldm_pkg::REG_DST_FOCAL:     dst_focal_r     <= cfg_data;
        ldm_pkg::REG_DST_CENTER:    dst_center_r    <= cfg_data;
        ldm_pkg::REG_RADIAL_K1_K2:  radial_k1_k2_r  <= cfg_data;
        ldm_pkg::REG_RADIAL_K3:     radial_k3_r     <= cfg_data[31:0];
        ldm_pkg::REG_TANG_P1_P2:    tang_p1_p2_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Coefficients sign-extended, pixel constants zero-extended.
  logic signed [W-1:0] k1_w, k2_w, k3_w, p1_w, p2_w;
  logic signed [W-1:0] ifx_w, ify_w, fx_w, fy_w, cdx_w, cdy_w;

  assign k1_w  = $signed({{32{radial_k1_k2_r[31]}}, radial_k1_k2_r[31:0]});
  assign k2_w  = $signed({{32{radial_k1_k2_r[63]}}, radial_k1_k2_r[63:32]});
  assign k3_w  = $signed({{32{radial_k3_r[31]}}, radial_k3_r});
  assign p1_w  = $signed({{32{tang_p1_p2_r[31]}}, tang_p1_p2_r[31:0]});
  assign p2_w  = $signed({{32{tang_p1_p2_r[63]}}, tang_p1_p2_r[63:32]});
  assign ifx_w = $signed({32'd0, src_inv_focal_r[31:0]});
  assign ify_w = $signed({32'd0, src_inv_focal_r[63:32]});
  assign fx_w  = $signed({32'd0, dst_focal_r[31:0]});
  assign fy_w  = $signed({32'd0, dst_focal_r[63:32]});
  assign cdx_w = $signed({32'd0, dst_center_r[31:0]});
  assign cdy_w = $signed({32'd0, dst_center_r[63:32]});

  // ---------------------------------------------------------------------------
  // Handshake and valid pipeline.
  // ---------------------------------------------------------------------------
  logic            busy_r;
  logic            in_acc;
  logic [ST_ABS:1] v_r;
  logic            out_valid_r;

  assign in_acc = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      v_r         <= {v_r[ST_ABS-1:1], in_acc};
      out_valid_r <= v_r[ST_ABS];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: offset from the source principal point, in Q.16.
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] dx_r, dy_r;

  always_ff @(posedge clk) begin
    dx_r <= $signed({{32{in_data.x_in[23]}}, in_data.x_in, 8'd0})
          - $signed({32'd0, src_center_r[31:0]});
    dy_r <= $signed({{32{in_data.y_in[23]}}, in_data.y_in, 8'd0})
          - $signed({32'd0, src_center_r[63:32]});
  end

  // Normalized point, Q.28.
  logic signed [W-1:0] xn, yn;
  logic                xn_sat, yn_sat;

  ldm_mul u_xn (.clk, .a(dx_r), .b(ifx_w), .sh_sel(ldm_pkg::SH_Q18), .p(xn), .sat(xn_sat));
  ldm_mul u_yn (.clk, .a(dy_r), .b(ify_w), .sh_sel(ldm_pkg::SH_Q18), .p(yn), .sat(yn_sat));

  // Squares and cross term.
  logic signed [W-1:0] x2, y2, xy;
  logic                x2_sat, y2_sat, xy_sat;

  ldm_mul u_x2 (.clk, .a(xn), .b(xn), .sh_sel(ldm_pkg::SH_Q28), .p(x2), .sat(x2_sat));
  ldm_mul u_y2 (.clk, .a(yn), .b(yn), .sh_sel(ldm_pkg::SH_Q28), .p(y2), .sat(y2_sat));
  ldm_mul u_xy (.clk, .a(xn), .b(yn), .sh_sel(ldm_pkg::SH_Q28), .p(xy), .sat(xy_sat));

  // r^2 and the doubled squares.
  ldm_pkg::sat_val_t r2_r, x2d_r, y2d_r;

  always_ff @(posedge clk) begin
    r2_r  <= ldm_pkg::add_sat(x2, y2);
    x2d_r <= ldm_pkg::add_sat(x2, x2);
    y2d_r <= ldm_pkg::add_sat(y2, y2);
  end

  // Tangential sums r^2 + 2x^2 and r^2 + 2y^2.
  ldm_pkg::sat_val_t tx_r, ty_r;

  always_ff @(posedge clk) begin
    tx_r <= ldm_pkg::add_sat(r2_r.val, x2d_r.val);
    ty_r <= ldm_pkg::add_sat(r2_r.val, y2d_r.val);
  end

  // Doubled cross terms 2*p1*xy and 2*p2*xy.
  logic signed [W-1:0] p1xy, p2xy;
  logic                p1xy_sat, p2xy_sat;

  ldm_mul u_p1xy (.clk, .a(p1_w), .b(xy), .sh_sel(ldm_pkg::SH_Q27), .p(p1xy),
                  .sat(p1xy_sat));
  ldm_mul u_p2xy (.clk, .a(p2_w), .b(xy), .sh_sel(ldm_pkg::SH_Q27), .p(p2xy),
                  .sat(p2xy_sat));

  // r^4 and the k1 term.
  logic signed [W-1:0] r4, k1r2;
  logic                r4_sat, k1r2_sat;

  ldm_mul u_r4 (.clk, .a(r2_r.val), .b(r2_r.val), .sh_sel(ldm_pkg::SH_Q28), .p(r4),
                .sat(r4_sat));
  ldm_mul u_k1 (.clk, .a(k1_w), .b(r2_r.val), .sh_sel(ldm_pkg::SH_Q28), .p(k1r2),
                .sat(k1r2_sat));

  // Tangential products p2*(r^2 + 2x^2) and p1*(r^2 + 2y^2).
  logic signed [W-1:0] p2tx, p1ty;
  logic                p2tx_sat, p1ty_sat;

  ldm_mul u_p2tx (.clk, .a(p2_w), .b(tx_r.val), .sh_sel(ldm_pkg::SH_Q28), .p(p2tx),
                  .sat(p2tx_sat));
  ldm_mul u_p1ty (.clk, .a(p1_w), .b(ty_r.val), .sh_sel(ldm_pkg::SH_Q28), .p(p1ty),
                  .sat(p1ty_sat));

  // Radial factor, accumulated in the same order as the terms rise in degree so
  // that saturation at each step is preserved.
  ldm_pkg::sat_val_t rad1_r, rad2_r, rad3_r;
  logic signed [W-1:0] r2_q, rad1_q, rad2_q;

  ldm_dly #(.W(W), .N(ST_R4 - ST_R2))   u_r2_dly   (.clk, .d(r2_r.val),   .q(r2_q));

  always_ff @(posedge clk) begin
    rad1_r <= ldm_pkg::add_sat(ldm_pkg::ONE_Q28, k1r2);
  end

  logic signed [W-1:0] r6, k2r4;
  logic                r6_sat, k2r4_sat;

  ldm_mul u_r6 (.clk, .a(r4), .b(r2_q), .sh_sel(ldm_pkg::SH_Q28), .p(r6), .sat(r6_sat));
  ldm_mul u_k2 (.clk, .a(k2_w), .b(r4), .sh_sel(ldm_pkg::SH_Q28), .p(k2r4),
                .sat(k2r4_sat));

  ldm_dly #(.W(W), .N(ST_R6 - ST_RAD1)) u_rad1_dly (.clk, .d(rad1_r.val), .q(rad1_q));

  always_ff @(posedge clk) begin
    rad2_r <= ldm_pkg::add_sat(rad1_q, k2r4);
  end

  logic signed [W-1:0] k3r6;
  logic                k3r6_sat;

  ldm_mul u_k3 (.clk, .a(k3_w), .b(r6), .sh_sel(ldm_pkg::SH_Q28), .p(k3r6),
                .sat(k3r6_sat));

  ldm_dly #(.W(W), .N(ST_K3 - ST_RAD2)) u_rad2_dly (.clk, .d(rad2_r.val), .q(rad2_q));

  always_ff @(posedge clk) begin
    rad3_r <= ldm_pkg::add_sat(rad2_q, k3r6);
  end

  // Radially scaled point.
  logic signed [W-1:0] xn_q, yn_q, xd0, yd0;
  logic                xd0_sat, yd0_sat;

  ldm_dly #(.W(W), .N(ST_RAD3 - ST_XN)) u_xn_dly (.clk, .d(xn), .q(xn_q));
  ldm_dly #(.W(W), .N(ST_RAD3 - ST_XN)) u_yn_dly (.clk, .d(yn), .q(yn_q));

  ldm_mul u_xd (.clk, .a(xn_q), .b(rad3_r.val), .sh_sel(ldm_pkg::SH_Q28), .p(xd0),
                .sat(xd0_sat));
  ldm_mul u_yd (.clk, .a(yn_q), .b(rad3_r.val), .sh_sel(ldm_pkg::SH_Q28), .p(yd0),
                .sat(yd0_sat));

  // Tangential terms added, first-listed term first for each axis.
  logic signed [W-1:0] p1xy_q, p2xy_q, p1ty_q, p2tx_q;
  ldm_pkg::sat_val_t   xd1_r, yd1_r, xd2_r, yd2_r;

  ldm_dly #(.W(W), .N(ST_D0 - ST_PXY)) u_p1xy_dly (.clk, .d(p1xy), .q(p1xy_q));
  ldm_dly #(.W(W), .N(ST_D1 - ST_PXY)) u_p2xy_dly (.clk, .d(p2xy), .q(p2xy_q));
  ldm_dly #(.W(W), .N(ST_D0 - ST_PT))  u_p1ty_dly (.clk, .d(p1ty), .q(p1ty_q));
  ldm_dly #(.W(W), .N(ST_D1 - ST_PT))  u_p2tx_dly (.clk, .d(p2tx), .q(p2tx_q));

  always_ff @(posedge clk) begin
    xd1_r <= ldm_pkg::add_sat(xd0, p1xy_q);
    yd1_r <= ldm_pkg::add_sat(yd0, p1ty_q);
    xd2_r <= ldm_pkg::add_sat(xd1_r.val, p2tx_q);
    yd2_r <= ldm_pkg::add_sat(yd1_r.val, p2xy_q);
  end

  // Projection onto the destination camera, Q.16.
  logic signed [W-1:0] px0, py0;
  logic                px0_sat, py0_sat;
  ldm_pkg::sat_val_t   px1_r, py1_r;

  ldm_mul u_px (.clk, .a(xd2_r.val), .b(fx_w), .sh_sel(ldm_pkg::SH_Q28), .p(px0),
                .sat(px0_sat));
  ldm_mul u_py (.clk, .a(yd2_r.val), .b(fy_w), .sh_sel(ldm_pkg::SH_Q28), .p(py0),
                .sat(py0_sat));

  always_ff @(posedge clk) begin
    px1_r <= ldm_pkg::add_sat(px0, cdx_w);
    py1_r <= ldm_pkg::add_sat(py0, cdy_w);
  end

  // Sign and magnitude ahead of the final rounding.
  logic           xneg_r, yneg_r;
  logic [W-2:0]   xmag_r, ymag_r;
  logic [W-1:0]   px_neg, py_neg;

  assign px_neg = W'(-px1_r.val);
  assign py_neg = W'(-py1_r.val);

  always_ff @(posedge clk) begin
    xneg_r <= px1_r.val[W-1];
    yneg_r <= py1_r.val[W-1];
    xmag_r <= px1_r.val[W-1] ? px_neg[W-2:0] : px1_r.val[W-2:0];
    ymag_r <= py1_r.val[W-1] ? py_neg[W-2:0] : py1_r.val[W-2:0];
  end

  // ---------------------------------------------------------------------------
  // Saturation flags. Each stage ORs in the flags of the values that land there,
  // so the running flag stays with its item down to the output.
  // ---------------------------------------------------------------------------
  logic [ST_P1:1]  hit;
  logic [ST_ABS:1] fl_r;

  always_comb begin
    hit = '0;
    hit[ST_XN]   = hit[ST_XN]   | xn_sat | yn_sat;
    hit[ST_SQ]   = hit[ST_SQ]   | x2_sat | y2_sat | xy_sat;
    hit[ST_R2]   = hit[ST_R2]   | r2_r.sat | x2d_r.sat | y2d_r.sat;
    hit[ST_T]    = hit[ST_T]    | tx_r.sat | ty_r.sat;
    hit[ST_PXY]  = hit[ST_PXY]  | p1xy_sat | p2xy_sat;
    hit[ST_R4]   = hit[ST_R4]   | r4_sat | k1r2_sat;
    hit[ST_PT]   = hit[ST_PT]   | p2tx_sat | p1ty_sat;
    hit[ST_RAD1] = hit[ST_RAD1] | rad1_r.sat;
    hit[ST_R6]   = hit[ST_R6]   | r6_sat | k2r4_sat;
    hit[ST_RAD2] = hit[ST_RAD2] | rad2_r.sat;
    hit[ST_K3]   = hit[ST_K3]   | k3r6_sat;
    hit[ST_RAD3] = hit[ST_RAD3] | rad3_r.sat;
    hit[ST_D0]   = hit[ST_D0]   | xd0_sat | yd0_sat;
    hit[ST_D1]   = hit[ST_D1]   | xd1_r.sat | yd1_r.sat;
    hit[ST_D2]   = hit[ST_D2]   | xd2_r.sat | yd2_r.sat;
    hit[ST_P0]   = hit[ST_P0]   | px0_sat | py0_sat;
    hit[ST_P1]   = hit[ST_P1]   | px1_r.sat | py1_r.sat;
  end

  always_ff @(posedge clk) begin
    fl_r[1] <= 1'b0;
    for (int k = 2; k <= ST_ABS; k++) begin
      fl_r[k] <= fl_r[k-1] | hit[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: round to Q.8, clamp to 24 bits, merge the flags.
  // ---------------------------------------------------------------------------
  clamp_t             xc, yc;
  ldm_pkg::out_item_t out_nxt, out_data_r;

  always_comb begin
    xc              = to_out24(xneg_r, xmag_r);
    yc              = to_out24(yneg_r, ymag_r);
    out_nxt.x_out   = $signed(xc.val);
    out_nxt.y_out   = $signed(yc.val);
    out_nxt.clipped = fl_r[ST_ABS] | xc.sat | yc.sat;
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // Every accepted item produces its result when it reaches stage ST_OUT.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##ST_OUT out_valid)
    else $error("accepted item did not produce a result on time");

  // No result without a matching accepted item that has reached stage ST_OUT.
  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, ST_OUT))
    else $error("result appeared without a matching accepted item");

  // Reset flushes the pipeline: no result is emitted right after it.
  a_reset_flush : assert property (@(posedge clk)
    !rst_n |=> !out_valid ##1 !out_valid)
    else $error("result emitted right after reset");

endmodule
`default_nettype wire
